@@ rtl/sha_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 hash core.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } sha_item_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/sha_queue.sv @@
// Small item queue between the input front and the compression engine.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_queue #(
  parameter int unsigned DEPTH = sha_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sha_pkg::sha_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output sha_pkg::sha_item_t  pop_item,
  output logic                empty
);
  import sha_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha_item_t             mem_r [DEPTH];
  logic [AW-1:0]         wptr_r, rptr_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  logic do_push, do_pop;
  assign full    = (cnt_r == ($clog2(DEPTH+1))'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_item = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance on push");
  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !do_pop) |=> full)
    else $error("full queue lost an item");
`endif
endmodule

@@ rtl/sha_engine.sv @@
// Block assembly, padding, 64-round compression and digest output.
// Depends on sha_pkg; fed from sha_queue.
`timescale 1ns / 1ps
module sha_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  sha_pkg::sha_item_t item,
  output logic               item_take,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last_word,
  output logic               out_empty,
  input  logic               out_pop
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PUT, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
  } state_t;

  state_t       state_r;
  logic [31:0]  w_r [16];
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [5:0]   nbytes_r;
  logic [63:0]  bits_r;
  logic [5:0]   round_r;
  logic [7:0]   byte_r;
  logic         last_r;     // end of message pending after current byte
  logic         padding_r;  // inside the padding sequence
  logic [63:0]  len_r;
  logic [3:0]   pad_len_idx_r;
  logic         pad_zero_r; // 0x80 already placed
  logic [2:0]   emit_idx_r;
  logic         emit_valid_r;

  // Schedule word for this round.
  logic [31:0] x2, x15, ws0, ws1, w_cur;
  logic [3:0]  t4;
  assign t4  = round_r[3:0];
  assign x2  = w_r[t4 - 4'd2];
  assign x15 = w_r[t4 - 4'd15];
  assign ws1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
  assign ws0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
  assign w_cur = (round_r >= 6'd16) ? (ws1 + w_r[t4 - 4'd7] + ws0 + w_r[t4]) : w_r[t4];

  logic [31:0] s1, chv, t1, s0, majv, t2;
  assign s1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign chv  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1   = v_r[7] + s1 + chv + RoundK[round_r] + w_cur;
  assign s0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign majv = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2   = s0 + majv;

  assign item_take   = (state_r == ST_IDLE) && item_valid;
  assign digest_word = h_r[emit_idx_r];
  assign word_index  = emit_idx_r;
  assign last_word   = (emit_idx_r == 3'd7);
  assign out_empty   = !emit_valid_r;

  logic [1:0] bpos;
  logic [3:0] bword;
  assign bpos  = nbytes_r[1:0];
  assign bword = nbytes_r[5:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      nbytes_r     <= '0;
      bits_r       <= '0;
      round_r      <= '0;
      last_r       <= 1'b0;
      padding_r    <= 1'b0;
      pad_zero_r   <= 1'b0;
      pad_len_idx_r <= '0;
      emit_idx_r   <= '0;
      emit_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (item_valid) begin
            byte_r    <= item.data;
            last_r    <= item.last;
            padding_r <= 1'b0;
            if (item.present) begin
              bits_r  <= bits_r + 64'd8;
              state_r <= ST_PUT;
            end else if (item.last) begin
              len_r         <= bits_r;
              padding_r     <= 1'b1;
              pad_zero_r    <= 1'b0;
              pad_len_idx_r <= '0;
              state_r       <= ST_PAD;
            end
          end
        end
        ST_PUT: begin
          // Place byte_r big-endian into the block.
          unique case (bpos)
            2'd0: w_r[bword] <= {byte_r, 24'h0};
            2'd1: w_r[bword][23:16] <= byte_r;
            2'd2: w_r[bword][15:8]  <= byte_r;
            2'd3: w_r[bword][7:0]   <= byte_r;
            default: ;
          endcase
          nbytes_r <= nbytes_r + 6'd1;
          if (nbytes_r == 6'd63) begin
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            round_r <= '0;
            state_r <= ST_ROUND;
          end else if (padding_r) begin
            state_r <= ST_PAD;
          end else if (last_r) begin
            len_r         <= bits_r;
            padding_r     <= 1'b1;
            pad_zero_r    <= 1'b0;
            pad_len_idx_r <= '0;
            state_r       <= ST_PAD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_ROUND: begin
          w_r[t4] <= w_cur;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          round_r <= round_r + 6'd1;
          if (round_r == 6'd63) state_r <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          round_r <= '0;
          if (padding_r) begin
            state_r <= (pad_len_idx_r == 4'd8) ? ST_EMIT : ST_PAD;
            if (pad_len_idx_r == 4'd8) begin
              emit_idx_r   <= '0;
              emit_valid_r <= 1'b1;
            end
          end else if (last_r) begin
            len_r         <= bits_r;
            padding_r     <= 1'b1;
            pad_zero_r    <= 1'b0;
            pad_len_idx_r <= '0;
            state_r       <= ST_PAD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_PAD: begin
          // Choose the next padding byte, then place it in ST_PUT.
          // Zero fill runs until byte 56 of a block, wrapping into a new block if needed.
          if (pad_len_idx_r == 4'd8) begin
            emit_idx_r   <= '0;
            emit_valid_r <= 1'b1;
            state_r      <= ST_EMIT;
          end else begin
            if (!pad_zero_r) begin
              byte_r     <= PadByte;
              pad_zero_r <= 1'b1;
            end else if (pad_len_idx_r == 4'd0 && nbytes_r != LenOffset) begin
              byte_r <= 8'h00;
            end else begin
              byte_r <= len_r[63 - 8*pad_len_idx_r[2:0] -: 8];
              pad_len_idx_r <= pad_len_idx_r + 4'd1;
            end
            state_r <= ST_PUT;
          end
        end
        ST_EMIT: begin
          if (out_pop) begin
            emit_idx_r <= emit_idx_r + 3'd1;
            if (emit_idx_r == 3'd7) begin
              emit_valid_r <= 1'b0;
              for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
              nbytes_r  <= '0;
              bits_r    <= '0;
              last_r    <= 1'b0;
              padding_r <= 1'b0;
              state_r   <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    emit_valid_r |-> (state_r == ST_EMIT))
    else $error("digest shown outside output phase");
  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && round_r != 6'd63) |=> (state_r == ST_ROUND))
    else $error("compression left early");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |-> !emit_valid_r)
    else $error("item taken during digest output");
`endif
endmodule

@@ rtl/sha256_hash_core.sv @@
// SHA-256 core: input queue in front of the compression engine.
// Each message byte passes through ST_IDLE and ST_PUT; a full block then runs ST_ROUND (one round a cycle) and ST_ADD.
// Padding bytes also pass through ST_PAD and ST_PUT and end in one or two compressed blocks;
// the digest follows as eight words, one per pop.
// Input bytes are taken only in ST_IDLE, so none is taken while a byte is placed or a block is compressed.
// Reset (rst_n low, synchronous) empties the queue, restores the initial hash values
// and clears the byte and bit counters.
`timescale 1ns / 1ps
module sha256_hash_core #(
  parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        push,
  output logic        full,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        empty,
  input  logic        pop
);
  import sha_pkg::*;

  sha_item_t in_item, q_item;
  logic      q_empty, q_take;

  assign in_item = '{data: in_data_byte, present: in_byte_present, last: in_end_of_message};

  sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_item(in_item), .full(full),
    .pop(q_take), .pop_item(q_item), .empty(q_empty)
  );

  sha_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .item_valid(!q_empty), .item(q_item), .item_take(q_take),
    .digest_word(out_digest_word), .word_index(out_word_index),
    .last_word(out_last_word), .out_empty(empty), .out_pop(pop)
  );

`ifndef SYNTHESIS
  a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last_word) |=> (!empty && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest words out of order");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_word) |-> (out_word_index == 3'd7))
    else $error("last word flag misplaced");
  a_take_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> !q_empty)
    else $error("engine took from empty queue");
`endif
endmodule

@@ test/sha256_hash_core_test.sv @@
// Testbench for the SHA-256 hash core: byte words in, digest words out.
// Depends on rtl/sha_pkg.sv (initial hash values, round constants) and the core itself.
`timescale 1ns / 1ps

class digest_board;
  logic [31:0] hash_state [8];
  logic [31:0] sched [16];
  int unsigned fill;
  logic [63:0] bit_len;
  logic [31:0] digest_q [$];
  logic [2:0] index_q [$];
  logic last_q [$];
  int mismatches;

  function new();
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::InitHash[i];
    fill = 0;
    bit_len = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, x2, x15;
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        x2 = sched[(t - 2) & 15];
        x15 = sched[(t - 15) & 15];
        s1 = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
        s0 = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
        sched[t & 15] = s1 + sched[(t - 7) & 15] + s0 + sched[t & 15];
      end
      s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t]
           + sched[t & 15];
      s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endfunction

  function void put(logic [7:0] b);
    if (fill % 4 == 0) sched[fill / 4] = '0;
    sched[fill / 4] |= 32'(b) << ((3 - fill % 4) * 8);
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endfunction

  // Notes one accepted input word and queues any digest it completes.
  function void note_word(logic [7:0] b, logic present, logic eom);
    logic [63:0] len;
    if (present) begin
      put(b);
      bit_len += 64'd8;
    end
    if (!eom) return;
    len = bit_len;
    put(sha_pkg::PadByte);
    while (fill != 56) put(8'h00);
    for (int i = 0; i < 8; i++) put(len[63 - 8 * i -: 8]);
    for (int i = 0; i < 8; i++) begin
      digest_q.push_back(hash_state[i]);
      index_q.push_back(3'(i));
      last_q.push_back(i == 7);
    end
    restart();
  endfunction

  function void report(string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endfunction

  function void check_word(logic [31:0] d, logic [2:0] idx, logic last);
    if (digest_q.size() == 0) begin
      report($sformatf("unexpected digest word %h", d));
      return;
    end
    if (d !== digest_q[0]) report($sformatf("digest %h, want %h", d, digest_q[0]));
    if (idx !== index_q[0]) report($sformatf("index %0d, want %0d", idx, index_q[0]));
    if (last !== last_q[0]) report($sformatf("last %b, want %b", last, last_q[0]));
    void'(digest_q.pop_front());
    void'(index_q.pop_front());
    void'(last_q.pop_front());
  endfunction
endclass

module sha256_hash_core_test;
  logic clk, rst_n;
  logic [7:0] in_data_byte;
  logic in_byte_present, in_end_of_message, push, full;
  logic [31:0] out_digest_word;
  logic [2:0] out_word_index;
  logic out_last_word, empty, pop;
  int send_idle, recv_stall;
  bit holding, stim_done;
  digest_board board;

  sha256_hash_core u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Sender: one word per call, with random idle cycles before it.
  // push stays high after the call so words can follow back to back.
  task automatic send_word(logic [7:0] b, logic present, logic eom);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    in_data_byte <= b;
    in_byte_present <= present;
    in_end_of_message <= eom;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_word(b, present, eom);
  endtask

  task automatic send_message(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_word(8'($urandom), 0, 0);
      send_word(8'($urandom), 1, i == n - 1);
    end
    if (n == 0) send_word(8'($urandom), 0, 1);
  endtask

  task automatic drain();
    push <= 0;
    while (board.digest_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Receiver: samples at the edge, decides the next pop level after it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) board.check_word(out_digest_word, out_word_index, out_last_word);
      pop <= !holding && ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic run_phase(int sidle, int rstall, int msgs);
    send_idle = sidle;
    recv_stall = rstall;
    for (int m = 0; m < msgs; m++)
      send_message($urandom_range(4) == 0 ? $urandom_range(56, 72) : $urandom_range(0, 12));
    drain();
  endtask

  initial begin
    board = new();
    rst_n = 0; push = 0; pop = 0; holding = 0;
    in_data_byte = 0; in_byte_present = 0; in_end_of_message = 0;
    send_idle = 0; recv_stall = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: empty message, idle word, "abc", padding edges at 55, 56 and 64 bytes.
    send_word(8'hff, 0, 1);
    send_word(8'h00, 0, 0);
    send_word(8'h61, 1, 0); send_word(8'h62, 1, 0); send_word(8'h63, 1, 1);
    send_word(8'h00, 1, 0); send_word(8'hff, 1, 1);
    send_message(55);
    send_message(56);
    send_message(64);
    drain();
    // Long hold-off so the input queue backs up.
    holding = 1;
    fork
      begin repeat (3000) @(posedge clk); holding = 0; end
      for (int m = 0; m < 4; m++) send_message($urandom_range(1, 10));
    join
    drain();
    run_phase(0, 0, 3);
    run_phase(63, 0, 3);
    run_phase(0, 63, 3);
    run_phase(24, 24, 3);
    drain();
    if (board.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
